// ===== hw/rtl/sixteen_bit_timer_with_prescaler_unit_macros.svh =====
// Assertion macros for the sixteen-bit timer unit.
`ifndef SIXTEEN_BIT_TIMER_WITH_PRESCALER_UNIT_MACROS_SVH
`define SIXTEEN_BIT_TIMER_WITH_PRESCALER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define STWP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define STWP_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define STWP_ASSERT(name, clk, rst_n, prop, msg)
`define STWP_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// ===== hw/rtl/stwp_pkg.sv =====
// Types, codes and helper functions of the sixteen-bit timer unit.
package stwp_pkg;

  // Operation carried by each input item.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_ACK   = 2'd3
  } op_e;

  // Bus register indexes.
  localparam logic [3:0] REG_CNT_LO   = 4'd0;
  localparam logic [3:0] REG_CNT_HI   = 4'd1;
  localparam logic [3:0] REG_CMPA_LO  = 4'd2;
  localparam logic [3:0] REG_CMPA_HI  = 4'd3;
  localparam logic [3:0] REG_CMPB_LO  = 4'd4;
  localparam logic [3:0] REG_CMPB_HI  = 4'd5;
  localparam logic [3:0] REG_CAPT_LO  = 4'd6;
  localparam logic [3:0] REG_CAPT_HI  = 4'd7;
  localparam logic [3:0] REG_FLAGS    = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLK_SEL   = 2'd0;
  localparam logic [1:0] CFG_WAVE_MODE = 2'd1;
  localparam logic [1:0] CFG_IRQ_MASK  = 2'd2;

  // Waveform modes.
  localparam logic [3:0] MODE_NORMAL   = 4'd0;
  localparam logic [3:0] MODE_CTC_CMPA = 4'd4;
  localparam logic [3:0] MODE_CTC_CAPT = 4'd12;

  // Flag register bit positions.
  localparam int unsigned FLAG_OVF_BIT   = 2;
  localparam int unsigned FLAG_MATCH_BIT = 4;

  localparam int unsigned PRESCALE_W = 11;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  // Clock select codes.
  localparam logic [2:0] CS_DIV1    = 3'd1;
  localparam logic [2:0] CS_DIV8    = 3'd2;
  localparam logic [2:0] CS_DIV64   = 3'd3;
  localparam logic [2:0] CS_DIV256  = 3'd4;
  localparam logic [2:0] CS_DIV1024 = 3'd5;

  typedef struct packed {
    op_e        op;
    logic [3:0] reg_index;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic       mode_error;
    logic [2:0] irq_bit;
    logic       irq_valid;
    logic [7:0] read_data;
  } out_item_t;

  // Prescaler bit whose toggle advances the counter; zero when stopped.
  function automatic logic [PRESCALE_W-1:0] divider_bit(input logic [2:0] sel);
    logic [PRESCALE_W-1:0] tap;
    tap = '0;
    case (sel)
      CS_DIV1:    tap[0]  = 1'b1;
      CS_DIV8:    tap[3]  = 1'b1;
      CS_DIV64:   tap[6]  = 1'b1;
      CS_DIV256:  tap[8]  = 1'b1;
      CS_DIV1024: tap[10] = 1'b1;
      default:    tap     = '0;
    endcase
    return tap;
  endfunction

endpackage

// ===== hw/rtl/sixteen_bit_timer_with_prescaler_unit.sv =====
// Sixteen-bit timer with prescaler, byte-wide register bus and interrupt acknowledge.
// Pipeline: an item passes the input register, then the result register.
// Throughput: one item per cycle unless the result side stalls; all state is updated in the
// single pass between the input and result registers, so the next item sees it at once.
// Reset: rst_ni clears the configuration, the prescaler, all timer registers and flags,
// the high-byte latch and both stage valid bits.
`include "sixteen_bit_timer_with_prescaler_unit_macros.svh"

module sixteen_bit_timer_with_prescaler_unit
  import stwp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // reg_index[3:0], write_data[11:4], zero pad
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // read_data[7:0], irq_valid[8], irq_bit[11:9],
                                     // mode_error[12], zero pad
);

  // Configuration registers.
  logic [2:0] clk_sel_q;
  logic [3:0] wave_mode_q;
  logic [7:0] irq_mask_q;

  // Timer state.
  logic [PRESCALE_W-1:0] pres_q, pres_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] cmpa_q, cmpa_d;
  logic [15:0] cmpb_q, cmpb_d;
  logic [15:0] capt_q, capt_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  temp_q, temp_d;

  // Pipeline registers.
  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res_d;

  logic      advance;
  logic      step;

  logic [PRESCALE_W-1:0] pres_inc;
  logic                  count_due;
  logic                  mode_ok;
  logic [15:0]           top;
  logic [7:0]            pend;
  logic                  irq_found;
  logic [2:0]            irq_sel;

  // Handshakes: the input stage moves on when the result register is free or drains.
  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_sel_q   <= '0;
      wave_mode_q <= '0;
      irq_mask_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLK_SEL:   clk_sel_q   <= cfg_data_i[2:0];
        CFG_WAVE_MODE: wave_mode_q <= cfg_data_i[3:0];
        CFG_IRQ_MASK:  irq_mask_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.op         <= op_e'(s_axis_tuser);
      in_q.reg_index  <= s_axis_tdata[3:0];
      in_q.write_data <= s_axis_tdata[11:4];
    end
  end

  // Shared terms of the tick and acknowledge paths.
  assign pres_inc  = pres_q + PRESCALE_W'(1);
  assign count_due = |((pres_q ^ pres_inc) & divider_bit(clk_sel_q));
  assign mode_ok   = (wave_mode_q == MODE_NORMAL) || (wave_mode_q == MODE_CTC_CMPA) ||
                     (wave_mode_q == MODE_CTC_CAPT);
  assign top       = (wave_mode_q == MODE_CTC_CMPA) ? cmpa_q : capt_q;
  assign pend      = flags_q & irq_mask_q;

  // Priority pick of the highest pending enabled flag.
  always_comb begin
    irq_found = 1'b0;
    irq_sel   = '0;
    for (int b = 0; b < 8; b++) begin
      if (pend[b]) begin
        irq_found = 1'b1;
        irq_sel   = 3'(b);
      end
    end
  end

  // Single pass: next state and result of the item in the input register.
  always_comb begin
    pres_d  = pres_q;
    cnt_d   = cnt_q;
    cmpa_d  = cmpa_q;
    cmpb_d  = cmpb_q;
    capt_d  = capt_q;
    flags_d = flags_q;
    temp_d  = temp_q;
    res_d   = '0;
    case (in_q.op)
      OP_TICK: begin
        pres_d = pres_inc;
        if (count_due) begin
          if (!mode_ok) begin
            res_d.mode_error = 1'b1;
          end else if (wave_mode_q != MODE_NORMAL && cnt_q == top) begin
            flags_d[FLAG_MATCH_BIT] = 1'b1;
            cnt_d = '0;
          end else if (cnt_q == COUNT_MAX) begin
            flags_d[FLAG_OVF_BIT] = 1'b1;
            cnt_d = '0;
          end else begin
            cnt_d = cnt_q + 16'd1;
          end
        end
      end
      OP_READ: begin
        case (in_q.reg_index)
          REG_CNT_LO: begin
            res_d.read_data = cnt_q[7:0];
            temp_d = cnt_q[15:8];
          end
          REG_CAPT_LO: begin
            res_d.read_data = capt_q[7:0];
            temp_d = capt_q[15:8];
          end
          REG_CNT_HI, REG_CAPT_HI: res_d.read_data = temp_q;
          REG_CMPA_LO: res_d.read_data = cmpa_q[7:0];
          REG_CMPA_HI: res_d.read_data = cmpa_q[15:8];
          REG_CMPB_LO: res_d.read_data = cmpb_q[7:0];
          REG_CMPB_HI: res_d.read_data = cmpb_q[15:8];
          REG_FLAGS:   res_d.read_data = flags_q;
          default:     res_d.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        case (in_q.reg_index)
          REG_CNT_HI, REG_CMPA_HI, REG_CMPB_HI, REG_CAPT_HI: temp_d = in_q.write_data;
          REG_CNT_LO:  cnt_d  = {temp_q, in_q.write_data};
          REG_CMPA_LO: cmpa_d = {temp_q, in_q.write_data};
          REG_CMPB_LO: cmpb_d = {temp_q, in_q.write_data};
          REG_CAPT_LO: capt_d = {temp_q, in_q.write_data};
          REG_FLAGS:   flags_d = flags_q & ~in_q.write_data;
          default: ;
        endcase
      end
      OP_ACK: begin
        if (irq_found) begin
          flags_d[irq_sel] = 1'b0;
          res_d.irq_valid  = 1'b1;
          res_d.irq_bit    = irq_sel;
        end
      end
      default: ;
    endcase
  end

  // Timer state update, one item per cycle unless the result side stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q  <= '0;
      cnt_q   <= '0;
      cmpa_q  <= '0;
      cmpb_q  <= '0;
      capt_q  <= '0;
      flags_q <= '0;
      temp_q  <= '0;
    end else if (step) begin
      pres_q  <= pres_d;
      cnt_q   <= cnt_d;
      cmpa_q  <= cmpa_d;
      cmpb_q  <= cmpb_d;
      capt_q  <= capt_d;
      flags_q <= flags_d;
      temp_q  <= temp_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res_d;
    end
  end

  // A mode error only comes from a tick, which never returns read data or an interrupt.
  `STWP_ASSERT(a_err_alone, clk_i, rst_ni,
      (out_valid_q && out_q.mode_error) |-> (out_q.read_data == 8'd0 && !out_q.irq_valid),
      "mode error with other result fields set")
  // An acknowledged flag is cleared in the following cycle.
  `STWP_ASSERT(a_ack_clears, clk_i, rst_ni,
      (step && in_q.op == OP_ACK && irq_found) |=> !flags_q[$past(irq_sel)],
      "acknowledged flag still pending")
  // A held input item stays in place while the result side is stalled.
  `STWP_ASSERT(a_in_hold, clk_i, rst_ni,
      (in_valid_q && !advance) |=> (in_valid_q && $stable(in_q)),
      "input stage lost or changed a stalled item")
  // A reported interrupt carries a zero read byte and no mode error.
  `STWP_ASSERT_NEVER(a_irq_clean, clk_i, rst_ni,
      out_valid_q && out_q.irq_valid && (out_q.mode_error || out_q.read_data != 8'd0),
      "interrupt result mixed with other fields")

endmodule

// ===== test/sixteen_bit_timer_with_prescaler_unit_tb.sv =====
// Self-checking testbench for the sixteen-bit timer unit: directed and random bus traffic.
module sixteen_bit_timer_with_prescaler_unit_tb;
  import stwp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 75;
  localparam int unsigned IDLE_PCT    = 37;

  // Configuration index past the last register; writes to it must be dropped.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  // Bus indexes with no register behind them.
  localparam logic [3:0] REG_SPARE_FIRST = 4'd9;
  localparam logic [3:0] REG_SPARE_LAST  = 4'd15;
  // Clock selects that never count, and a waveform mode with no support.
  localparam logic [2:0] CS_STOP     = 3'd0;
  localparam logic [2:0] CS_NONE_LO  = 3'd6;
  localparam logic [2:0] CS_NONE_HI  = 3'd7;
  localparam logic [3:0] MODE_SPARE  = 4'hF;

  localparam logic [3:0] WIDE_LO [4] = '{REG_CNT_LO, REG_CMPA_LO, REG_CMPB_LO, REG_CAPT_LO};
  localparam logic [3:0] WIDE_HI [4] = '{REG_CNT_HI, REG_CMPA_HI, REG_CMPB_HI, REG_CAPT_HI};

  // Timer state mirror and the queue of results still owed by the block.
  class timer_scoreboard;
    bit [2:0]  clk_sel;
    bit [3:0]  wave;
    bit [7:0]  irq_en;
    bit [10:0] prescale;
    bit [15:0] count;
    bit [15:0] cmp_a;
    bit [15:0] cmp_b;
    bit [15:0] capt;
    bit [7:0]  flags;
    bit [7:0]  hi_latch;
    out_item_t pending_results[$];
    int        errors;

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return pending_results.size();
    endfunction

    function void note_config(input bit [1:0] idx, input bit [7:0] data);
      case (idx)
        CFG_CLK_SEL:   clk_sel = data[2:0];
        CFG_WAVE_MODE: wave = data[3:0];
        CFG_IRQ_MASK:  irq_en = data;
        default: ;
      endcase
    endfunction

    // Prescaler bit watched by each clock select; -1 when the timer is stopped.
    function int tap_position(input bit [2:0] sel);
      case (sel)
        CS_DIV1:    return 0;
        CS_DIV8:    return 3;
        CS_DIV64:   return 6;
        CS_DIV256:  return 8;
        CS_DIV1024: return 10;
        default:    return -1;
      endcase
    endfunction

    // One count of the timer; returns one when the waveform mode is unsupported.
    function bit count_once();
      bit [15:0] top;
      if (wave != MODE_NORMAL && wave != MODE_CTC_CMPA && wave != MODE_CTC_CAPT)
        return 1'b1;
      top = (wave == MODE_CTC_CMPA) ? cmp_a : capt;
      if (wave != MODE_NORMAL && count == top) begin
        flags[FLAG_MATCH_BIT] = 1'b1;
        count = '0;
      end else if (count == COUNT_MAX) begin
        flags[FLAG_OVF_BIT] = 1'b1;
        count = '0;
      end else begin
        count++;
      end
      return 1'b0;
    endfunction

    // Low bytes of counter and capture load the latch; their high bytes return it.
    function bit [7:0] read_byte(input bit [3:0] idx);
      bit [15:0] word;
      case (idx)
        REG_FLAGS:   return flags;
        REG_CMPA_LO: return cmp_a[7:0];
        REG_CMPA_HI: return cmp_a[15:8];
        REG_CMPB_LO: return cmp_b[7:0];
        REG_CMPB_HI: return cmp_b[15:8];
        REG_CNT_LO, REG_CAPT_LO: begin
          word = (idx == REG_CNT_LO) ? count : capt;
          hi_latch = word[15:8];
          return word[7:0];
        end
        REG_CNT_HI, REG_CAPT_HI: return hi_latch;
        default: return 8'h00;
      endcase
    endfunction

    // High bytes only load the latch; low bytes commit the whole word.
    function void write_byte(input bit [3:0] idx, input bit [7:0] data);
      case (idx)
        REG_FLAGS: flags &= ~data;
        REG_CNT_HI, REG_CMPA_HI, REG_CMPB_HI, REG_CAPT_HI: hi_latch = data;
        REG_CNT_LO:  count = {hi_latch, data};
        REG_CMPA_LO: cmp_a = {hi_latch, data};
        REG_CMPB_LO: cmp_b = {hi_latch, data};
        REG_CAPT_LO: capt = {hi_latch, data};
        default: ;
      endcase
    endfunction

    function void note_input(input op_e op, input bit [3:0] idx, input bit [7:0] data);
      out_item_t res;
      bit [10:0] nxt;
      int tap;
      res = '0;
      case (op)
        OP_TICK: begin
          nxt = prescale + 11'd1;
          tap = tap_position(clk_sel);
          if (tap >= 0 && prescale[tap] != nxt[tap])
            res.mode_error = count_once();
          prescale = nxt;
        end
        OP_READ:  res.read_data = read_byte(idx);
        OP_WRITE: write_byte(idx, data);
        default: begin
          // Highest enabled pending flag wins and is cleared.
          for (int b = 7; b >= 0; b--) begin
            if (!res.irq_valid && flags[b] && irq_en[b]) begin
              flags[b] = 1'b0;
              res.irq_valid = 1'b1;
              res.irq_bit = 3'(b);
            end
          end
        end
      endcase
      pending_results.push_back(res);
    endfunction

    task check_result(input logic [15:0] tdata);
      out_item_t got;
      out_item_t want;
      got = out_item_t'(tdata[12:0]);
      if (pending_results.size() == 0) begin
        report($sformatf("result %h arrived with nothing outstanding", tdata));
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
      if (got.irq_valid !== want.irq_valid)
        report($sformatf("irq_valid %b, want %b", got.irq_valid, want.irq_valid));
      if (got.irq_bit !== want.irq_bit)
        report($sformatf("irq_bit %0d, want %0d", got.irq_bit, want.irq_bit));
      if (got.mode_error !== want.mode_error)
        report($sformatf("mode_error %b, want %b", got.mode_error, want.mode_error));
      if (tdata[15:13] !== 3'b000)
        report($sformatf("pad bits %b not zero", tdata[15:13]));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  timer_scoreboard sb;
  bit steady = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int unsigned cycles = 0;

  sixteen_bit_timer_with_prescaler_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sixteen_bit_timer_with_prescaler_unit verification failed");
      $finish;
    end
  end

  // Result side: random back-pressure, plus long hold-offs on request.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Every result transfer is checked against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  // Offers one item after a random gap and returns once it has been transferred.
  task automatic send_item(input op_e op, input logic [3:0] idx, input logic [7:0] data);
    int gaps;
    gaps = 0;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT)
      gaps++;
    if (gaps > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, data, idx};
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(op, idx, data);
  endtask

  // Sender stops until the block has delivered everything and gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.note_config(idx, data);
  endtask

  // Unused upper bits of the clock select and waveform mode are filled at random; the block must drop them.
  task automatic apply_config(input logic [2:0] cs, input logic [3:0] mode,
                              input logic [7:0] mask, input bit spare);
    cfg_write(CFG_CLK_SEL, {5'($urandom), cs});
    cfg_write(CFG_WAVE_MODE, {4'($urandom), mode});
    cfg_write(CFG_IRQ_MASK, mask);
    if (spare)
      cfg_write(CFG_SPARE, 8'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_word(input int sel, input logic [15:0] word);
    send_item(OP_WRITE, WIDE_HI[sel], word[15:8]);
    send_item(OP_WRITE, WIDE_LO[sel], word[7:0]);
  endtask

  // Mostly latch-correct 16-bit accesses and ticks, with stray single-byte traffic.
  task automatic run_random(input int n);
    int sent;
    int r;
    int sel;
    logic [15:0] word;
    logic [3:0] idx;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      sel = $urandom_range(0, 3);
      if (r < 15) begin
        case ($urandom_range(0, 2))
          0:       word = COUNT_MAX - 16'($urandom_range(0, 15));
          1:       word = 16'($urandom_range(0, 24));
          default: word = 16'($urandom);
        endcase
        write_word(sel, word);
        sent += 2;
      end else if (r < 25) begin
        send_item(OP_READ, WIDE_LO[sel], 8'($urandom));
        send_item(OP_READ, WIDE_HI[sel], 8'($urandom));
        sent += 2;
      end else if (r < 60) begin
        send_item(OP_TICK, 4'($urandom), 8'($urandom));
        sent++;
      end else if (r < 70) begin
        send_item(OP_ACK, 4'($urandom), 8'($urandom));
        sent++;
      end else if (r < 78) begin
        send_item(OP_WRITE, REG_FLAGS, 8'($urandom));
        sent++;
      end else if (r < 88) begin
        send_item(OP_READ, 4'($urandom), 8'($urandom));
        sent++;
      end else begin
        idx = 4'($urandom);
        send_item(OP_WRITE, idx, 8'($urandom));
        if (idx <= REG_FLAGS)
          sent++;
      end
    end
  endtask

  initial begin
    logic [2:0] cs;
    logic [3:0] mode;
    logic [7:0] mask;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: timer stopped, nothing enabled.
    send_item(OP_READ, REG_CNT_LO, 8'h00);
    send_item(OP_TICK, REG_CNT_LO, 8'h00);
    send_item(OP_ACK, REG_CNT_LO, 8'h00);
    send_item(OP_READ, REG_FLAGS, 8'h00);
    settle();

    // Directed: overflow, acknowledge, latch behavior and unknown indexes.
    apply_config(CS_DIV1, MODE_NORMAL, 8'hFF, 1'b0);
    write_word(0, 16'hFFFD);
    repeat (3) send_item(OP_TICK, REG_CNT_LO, 8'h00);
    send_item(OP_READ, REG_FLAGS, 8'h00);
    send_item(OP_ACK, REG_CNT_LO, 8'h00);
    send_item(OP_ACK, REG_CNT_LO, 8'h00);
    write_word(1, 16'h1234);
    send_item(OP_READ, REG_CMPA_LO, 8'h00);
    send_item(OP_READ, REG_CMPA_HI, 8'h00);
    write_word(2, 16'hABCD);
    send_item(OP_READ, REG_CMPB_LO, 8'h00);
    send_item(OP_READ, REG_CMPB_HI, 8'h00);
    write_word(3, COUNT_MAX);
    send_item(OP_READ, REG_CAPT_LO, 8'h00);
    send_item(OP_READ, REG_CAPT_HI, 8'h00);
    send_item(OP_READ, REG_CNT_LO, 8'h00);
    send_item(OP_READ, REG_CNT_HI, 8'h00);
    send_item(OP_WRITE, REG_FLAGS, 8'hFF);
    send_item(OP_READ, REG_SPARE_LAST, 8'h00);
    send_item(OP_WRITE, REG_SPARE_FIRST, 8'hAA);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0)
        settle();
      steady = 1'b0;
      case (p)
        0:  begin cs = CS_DIV1;    mode = MODE_NORMAL;   mask = 8'hFF; end
        1:  begin cs = CS_DIV1;    mode = MODE_CTC_CMPA; mask = 8'hFF; end
        2:  begin cs = CS_DIV1;    mode = MODE_CTC_CAPT; mask = 8'h14; end
        3:  begin cs = CS_DIV8;    mode = MODE_CTC_CMPA; mask = 8'h10; end
        4:  begin cs = CS_STOP;    mode = MODE_NORMAL;   mask = 8'hFF; end
        5:  begin cs = CS_NONE_HI; mode = MODE_CTC_CMPA; mask = 8'h04; end
        6:  begin cs = CS_NONE_LO; mode = MODE_NORMAL;   mask = 8'h00; end
        7:  begin cs = CS_DIV1;    mode = MODE_SPARE;    mask = 8'hFF; end
        8:  begin cs = CS_DIV64;   mode = MODE_CTC_CAPT; mask = 8'hFF; end
        9:  begin cs = CS_DIV1024; mode = MODE_NORMAL;   mask = 8'hFF; end
        10: begin cs = CS_DIV256;  mode = 4'($urandom);  mask = 8'($urandom); end
        default: begin
          cs = CS_DIV1;
          mask = 8'hEF;
          do mode = 4'($urandom);
          while (mode == MODE_NORMAL || mode == MODE_CTC_CMPA || mode == MODE_CTC_CAPT);
        end
      endcase
      if (p > 0)
        apply_config(cs, mode, mask, (p % 4) == 1);

      case (p)
        1: begin
          // Small compare-A top: the counter clears on match.
          write_word(1, 16'h0003);
          write_word(0, 16'h0000);
          repeat (6) send_item(OP_TICK, REG_CNT_LO, 8'h00);
          send_item(OP_ACK, REG_CNT_LO, 8'h00);
        end
        2: begin
          // Top of all ones: only the match flag may be set. No idling here.
          steady = 1'b1;
          write_word(3, COUNT_MAX);
          write_word(0, 16'hFFFE);
          repeat (3) send_item(OP_TICK, REG_CNT_LO, 8'h00);
          send_item(OP_READ, REG_FLAGS, 8'h00);
        end
        3: begin
          // Result side stalls for a long stretch while items keep coming.
          steady = 1'b1;
          hold_requests <= hold_requests + 1;
        end
        default: ;
      endcase
      run_random(PHASE_ITEMS);
    end

    settle();
    if (sb.errors == 0)
      $display("sixteen_bit_timer_with_prescaler_unit verification clean");
    else
      $display("sixteen_bit_timer_with_prescaler_unit verification failed");
    $finish;
  end

endmodule
